[sv/csim_pkg.sv]
// Shared constants, queue entry type and back-end state type for the
// cosine similarity engine. No dependencies.
`default_nettype none

package csim_pkg;

  localparam int MAX_LEN    = 4096;   // pairs accumulated per vector
  localparam int ELEM_W     = 16;     // element width
  localparam int PAIR_W     = 2 * ELEM_W;
  localparam int SQ_W       = 43;     // sum of squares width
  localparam int DOT_W      = 44;     // dot product width
  localparam int CNT_W      = $clog2(MAX_LEN + 1);
  localparam int COS_W      = 16;
  localparam int COS_ONE    = 16384;  // 1.0 in Q1.14
  localparam int COS_FRAC   = 14;
  localparam int PROD_W     = 2 * SQ_W;          // norm product width
  localparam int ROOT_W     = PROD_W / 2;        // root digits, two radicand bits each
  localparam int HALF_W     = (SQ_W + 1) / 2;    // operand split for partial products
  localparam int PP_W       = 2 * HALF_W;
  localparam int NUM_W      = DOT_W + COS_FRAC;  // dividend width
  localparam int MUL_STEPS  = 4;
  localparam int STEP_W     = 6;
  localparam int Q_DEPTH    = 2;
  localparam int Q_PTR_W    = $clog2(Q_DEPTH);
  localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);
  localparam int OUT_DATA_W = 64;
  localparam int OUT_USER_W = 2;

  typedef struct packed {
    logic                    too_long;
    logic signed [DOT_W-1:0] dot;
    logic [SQ_W-1:0]         sum_b;
    logic [SQ_W-1:0]         sum_a;
  } csim_entry_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL,
    BK_ROOT,
    BK_DIV,
    BK_OUT
  } csim_bk_state_t;

endpackage

`default_nettype wire

[sv/csim_front.sv]
// Front end: accepts element pairs, squares and multiplies them, and keeps the
// three running sums. Pushes one entry per finished vector. Uses csim_pkg.
`default_nettype none

module csim_front (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [csim_pkg::PAIR_W-1:0]   in_tdata,
  input  wire logic                          in_tlast,
  input  wire logic [csim_pkg::Q_CNT_W-1:0]  q_count,
  output logic                               q_push,
  output csim_pkg::csim_entry_t              q_entry
);

  logic                                accept;
  logic signed [csim_pkg::ELEM_W-1:0]  elem_a;
  logic signed [csim_pkg::ELEM_W-1:0]  elem_b;
  logic                                drop;
  logic                                pending;

  logic [csim_pkg::CNT_W-1:0]          count_r;
  logic                                ovf_r;

  logic                                v1_r;
  logic                                last1_r;
  logic                                drop1_r;
  logic                                tl1_r;
  logic signed [csim_pkg::PAIR_W-1:0]  sqa1_r;
  logic signed [csim_pkg::PAIR_W-1:0]  sqb1_r;
  logic signed [csim_pkg::PAIR_W-1:0]  crs1_r;

  logic [csim_pkg::SQ_W-1:0]           suma_r, suma_nxt;
  logic [csim_pkg::SQ_W-1:0]           sumb_r, sumb_nxt;
  logic [csim_pkg::DOT_W-1:0]          dot_r, dot_nxt;

  assign elem_a  = in_tdata[csim_pkg::ELEM_W-1:0];
  assign elem_b  = in_tdata[csim_pkg::PAIR_W-1:csim_pkg::ELEM_W];
  assign accept  = in_tvalid & in_tready;
  assign drop    = (count_r == csim_pkg::CNT_W'(csim_pkg::MAX_LEN));
  assign pending = v1_r & last1_r;

  // Hold off while the queue could not take a vector end already in flight.
  assign in_tready = ((csim_pkg::Q_CNT_W + 1)'(q_count) + (csim_pkg::Q_CNT_W + 1)'(pending))
                     < (csim_pkg::Q_CNT_W + 1)'(csim_pkg::Q_DEPTH);

  // Pair count and overflow flag track accepted pairs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
      v1_r    <= 1'b0;
    end else begin
      v1_r <= accept;
      if (accept) begin
        if (in_tlast) begin
          count_r <= '0;
          ovf_r   <= 1'b0;
        end else if (drop) begin
          ovf_r <= 1'b1;
        end else begin
          count_r <= count_r + 1'b1;
        end
      end
    end
  end

  // Products stage.
  always_ff @(posedge clk) begin
    if (accept) begin
      sqa1_r  <= elem_a * elem_a;
      sqb1_r  <= elem_b * elem_b;
      crs1_r  <= elem_a * elem_b;
      last1_r <= in_tlast;
      drop1_r <= drop;
      tl1_r   <= ovf_r | drop;
    end
  end

  // Accumulate stage.
  always_comb begin
    suma_nxt = suma_r;
    sumb_nxt = sumb_r;
    dot_nxt  = dot_r;
    if (!drop1_r) begin
      suma_nxt = suma_r + csim_pkg::SQ_W'(unsigned'(sqa1_r));
      sumb_nxt = sumb_r + csim_pkg::SQ_W'(unsigned'(sqb1_r));
      dot_nxt  = dot_r + csim_pkg::DOT_W'(crs1_r);
    end
  end

  assign q_push           = pending;
  assign q_entry.too_long = tl1_r;
  assign q_entry.dot      = dot_nxt;
  assign q_entry.sum_b    = sumb_nxt;
  assign q_entry.sum_a    = suma_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      suma_r <= '0;
      sumb_r <= '0;
      dot_r  <= '0;
    end else if (v1_r) begin
      if (last1_r) begin
        suma_r <= '0;
        sumb_r <= '0;
        dot_r  <= '0;
      end else begin
        suma_r <= suma_nxt;
        sumb_r <= sumb_nxt;
        dot_r  <= dot_nxt;
      end
    end
  end

endmodule

`default_nettype wire

[sv/csim_queue.sv]
// Short queue of finished vector sums between front and back end.
// Uses csim_pkg for the entry type and depth.
`default_nettype none

module csim_queue (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          push,
  input  wire csim_pkg::csim_entry_t         push_entry,
  input  wire logic                          pop,
  output logic                               q_valid,
  output csim_pkg::csim_entry_t              q_entry,
  output logic [csim_pkg::Q_CNT_W-1:0]       q_count
);

  csim_pkg::csim_entry_t               mem_r [csim_pkg::Q_DEPTH];
  logic [csim_pkg::Q_PTR_W-1:0]        wr_ptr_r;
  logic [csim_pkg::Q_PTR_W-1:0]        rd_ptr_r;
  logic [csim_pkg::Q_CNT_W-1:0]        count_r;

  assign q_valid = (count_r != '0);
  assign q_entry = mem_r[rd_ptr_r];
  assign q_count = count_r;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == csim_pkg::Q_PTR_W'(csim_pkg::Q_DEPTH - 1)) ? '0
                    : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == csim_pkg::Q_PTR_W'(csim_pkg::Q_DEPTH - 1)) ? '0
                    : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (count_r < csim_pkg::Q_CNT_W'(csim_pkg::Q_DEPTH)))
    else $error("queue push while full");

  a_no_underrun: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (count_r != '0))
    else $error("queue pop while empty");

  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("queue count lost a push");

endmodule

`default_nettype wire

[sv/csim_back.sv]
// Back end: norm product by partial products, bit-pair square root, restoring
// divide, clamp, and the result register. Uses csim_pkg.
`default_nettype none

module csim_back (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              q_valid,
  input  wire csim_pkg::csim_entry_t             q_entry,
  output logic                                   q_pop,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [csim_pkg::OUT_DATA_W-1:0]        out_tdata,
  output logic [csim_pkg::OUT_USER_W-1:0]        out_tuser
);

  csim_pkg::csim_bk_state_t            state_r, state_nxt;
  logic [csim_pkg::STEP_W-1:0]         cnt_r;
  logic                                out_free;
  logic                                zn_in;

  logic [csim_pkg::SQ_W-1:0]           sa_r;
  logic [csim_pkg::SQ_W-1:0]           sb_r;
  logic signed [csim_pkg::DOT_W-1:0]   dot_r;
  logic                                tl_r;
  logic                                zn_r;

  logic [csim_pkg::HALF_W-1:0]         mul_x, mul_y;
  logic [csim_pkg::PP_W-1:0]           pp_r;
  logic [1:0]                          psel_r;
  logic [csim_pkg::PROD_W-1:0]         pp_sh;
  logic [csim_pkg::PROD_W-1:0]         prod_r;

  logic [csim_pkg::PROD_W-1:0]         rad_r;
  logic [csim_pkg::ROOT_W+1:0]         rem_r;
  logic [csim_pkg::ROOT_W-1:0]         root_r, root_nxt;
  logic [csim_pkg::ROOT_W+3:0]         remsh, trial;
  logic [csim_pkg::ROOT_W+1:0]         rem_nxt;

  logic [csim_pkg::DOT_W-1:0]          dot_mag;
  logic [csim_pkg::NUM_W-1:0]          num_r;
  logic [csim_pkg::NUM_W-1:0]          quo_r;
  logic [csim_pkg::ROOT_W-1:0]         drem_r;
  logic [csim_pkg::ROOT_W:0]           dsh;
  logic                                dfit;

  logic [csim_pkg::COS_W-1:0]          cos_mag;
  logic [csim_pkg::COS_W-1:0]          cos_val;

  logic                                out_valid_r;
  logic signed [csim_pkg::DOT_W-1:0]   out_dot_r;
  logic [csim_pkg::COS_W-1:0]          out_cos_r;
  logic                                out_zn_r;
  logic                                out_tl_r;

  assign out_free = !out_valid_r || out_tready;
  assign zn_in    = (q_entry.sum_a == '0) || (q_entry.sum_b == '0);

  // Control.
  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    unique case (state_r)
      csim_pkg::BK_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          state_nxt = zn_in ? csim_pkg::BK_OUT : csim_pkg::BK_MUL;
        end
      end
      csim_pkg::BK_MUL: begin
        if (cnt_r == csim_pkg::STEP_W'(csim_pkg::MUL_STEPS)) state_nxt = csim_pkg::BK_ROOT;
      end
      csim_pkg::BK_ROOT: begin
        if (cnt_r == csim_pkg::STEP_W'(csim_pkg::ROOT_W - 1)) state_nxt = csim_pkg::BK_DIV;
      end
      csim_pkg::BK_DIV: begin
        if (cnt_r == csim_pkg::STEP_W'(csim_pkg::NUM_W - 1)) state_nxt = csim_pkg::BK_OUT;
      end
      csim_pkg::BK_OUT: begin
        if (out_free) state_nxt = csim_pkg::BK_IDLE;
      end
      default: state_nxt = csim_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= csim_pkg::BK_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= (state_nxt != state_r) ? '0 : cnt_r + 1'b1;
    end
  end

  // Partial product operands: low/high halves of each sum of squares.
  assign mul_x = cnt_r[1] ? csim_pkg::HALF_W'(sa_r[csim_pkg::SQ_W-1:csim_pkg::HALF_W])
                          : sa_r[csim_pkg::HALF_W-1:0];
  assign mul_y = cnt_r[0] ? csim_pkg::HALF_W'(sb_r[csim_pkg::SQ_W-1:csim_pkg::HALF_W])
                          : sb_r[csim_pkg::HALF_W-1:0];

  always_comb begin
    unique case (psel_r)
      2'd0:         pp_sh = csim_pkg::PROD_W'(pp_r);
      2'd1, 2'd2:   pp_sh = csim_pkg::PROD_W'(pp_r) << csim_pkg::HALF_W;
      default:      pp_sh = csim_pkg::PROD_W'(pp_r) << (2 * csim_pkg::HALF_W);
    endcase
  end

  // One square-root digit: bring down two radicand bits, try 4r+1.
  assign remsh = {rem_r, rad_r[csim_pkg::PROD_W-1:csim_pkg::PROD_W-2]};
  assign trial = {2'b00, root_r, 2'b01};
  always_comb begin
    if (remsh >= trial) begin
      rem_nxt  = (csim_pkg::ROOT_W + 2)'(remsh - trial);
      root_nxt = {root_r[csim_pkg::ROOT_W-2:0], 1'b1};
    end else begin
      rem_nxt  = (csim_pkg::ROOT_W + 2)'(remsh);
      root_nxt = {root_r[csim_pkg::ROOT_W-2:0], 1'b0};
    end
  end

  // Divide on magnitudes; sign goes back on at the end.
  assign dot_mag = dot_r[csim_pkg::DOT_W-1] ? csim_pkg::DOT_W'(-dot_r)
                                             : csim_pkg::DOT_W'(dot_r);
  assign dsh  = {drem_r, num_r[csim_pkg::NUM_W-1]};
  assign dfit = (dsh >= {1'b0, root_r});

  // Clamp to one; cannot trip for sums that have not wrapped.
  assign cos_mag = (quo_r > csim_pkg::NUM_W'(csim_pkg::COS_ONE))
                   ? csim_pkg::COS_W'(csim_pkg::COS_ONE) : quo_r[csim_pkg::COS_W-1:0];
  assign cos_val = zn_r ? '0
                   : (dot_r[csim_pkg::DOT_W-1] ? (-cos_mag) : cos_mag);

  // Datapath.
  always_ff @(posedge clk) begin
    unique case (state_r)
      csim_pkg::BK_IDLE: begin
        if (q_valid) begin
          sa_r   <= q_entry.sum_a;
          sb_r   <= q_entry.sum_b;
          dot_r  <= q_entry.dot;
          tl_r   <= q_entry.too_long;
          zn_r   <= zn_in;
          prod_r <= '0;
        end
      end
      csim_pkg::BK_MUL: begin
        if (cnt_r < csim_pkg::STEP_W'(csim_pkg::MUL_STEPS)) begin
          pp_r   <= mul_x * mul_y;
          psel_r <= cnt_r[1:0];
        end
        if (cnt_r != '0) prod_r <= prod_r + pp_sh;
        if (cnt_r == csim_pkg::STEP_W'(csim_pkg::MUL_STEPS)) begin
          rad_r  <= prod_r + pp_sh;
          rem_r  <= '0;
          root_r <= '0;
        end
      end
      csim_pkg::BK_ROOT: begin
        rem_r  <= rem_nxt;
        root_r <= root_nxt;
        rad_r  <= rad_r << 2;
        if (cnt_r == csim_pkg::STEP_W'(csim_pkg::ROOT_W - 1)) begin
          num_r  <= {dot_mag, csim_pkg::COS_FRAC'(0)};
          quo_r  <= '0;
          drem_r <= '0;
        end
      end
      csim_pkg::BK_DIV: begin
        num_r  <= num_r << 1;
        quo_r  <= {quo_r[csim_pkg::NUM_W-2:0], dfit};
        drem_r <= dfit ? csim_pkg::ROOT_W'(dsh - {1'b0, root_r})
                       : csim_pkg::ROOT_W'(dsh);
      end
      csim_pkg::BK_OUT: begin
        if (out_free) begin
          out_dot_r <= dot_r;
          out_cos_r <= cos_val;
          out_zn_r  <= zn_r;
          out_tl_r  <= tl_r;
        end
      end
      default: begin
      end
    endcase
  end

  // Result register: next vector may start while this one waits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == csim_pkg::BK_OUT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(csim_pkg::OUT_DATA_W - csim_pkg::DOT_W - csim_pkg::COS_W)'(0),
                       out_cos_r, out_dot_r};
  assign out_tuser  = {out_tl_r, out_zn_r};

  a_zero_norm_cos: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_zn_r) |-> (out_cos_r == '0))
    else $error("zero norm result with nonzero cosine");

  a_cos_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_cos_r) <= $signed(csim_pkg::COS_W'(csim_pkg::COS_ONE)) &&
                    $signed(out_cos_r) >= -$signed(csim_pkg::COS_W'(csim_pkg::COS_ONE))))
    else $error("cosine outside unit range");

  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == csim_pkg::BK_OUT && !out_free) |=> (state_r == csim_pkg::BK_OUT))
    else $error("finished result dropped while output busy");

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (state_r != csim_pkg::BK_IDLE))
    else $error("popped entry not taken up");

endmodule

`default_nettype wire

[sv/cosine_similarity_engine.sv]
// Top level of the cosine similarity engine: front end, sum queue, back end.
// Depends on csim_pkg, csim_front, csim_queue and csim_back.
//
// Usage
//   Input channel (in_*): one element pair per request, elem_a in
//   in_tdata[15:0], elem_b in in_tdata[31:16], in_tlast on the final pair of
//   the two vectors. Up to 4096 pairs are summed; later pairs are dropped
//   and flagged.
//   Output channel (out_*): one request per vector. out_tdata[43:0] is the
//   dot product, out_tdata[59:44] the Q1.14 cosine truncated toward zero;
//   out_tuser[0] zero_norm, out_tuser[1] too_long.
// Throughput: one pair per cycle while in_tready is high. Each vector then
//   passes through the back end (4 partial-product steps plus drain, 43
//   square-root digits, 58 divide steps, one load into the result register),
//   or goes straight to the load when a norm is zero. The back end handles
//   one vector at a time; a two-entry queue lets the next vector stream in
//   meanwhile.
// Reset: rst_n low clears sums, counters, queue and result valid.
// Stall: with out_tready low the result holds; the back end finishes the
//   next vector and waits; once the queue is full in_tready drops.
`default_nettype none

module cosine_similarity_engine (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [csim_pkg::PAIR_W-1:0]       in_tdata,   // elem_a, elem_b
  input  wire logic                              in_tlast,   // last pair
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [csim_pkg::OUT_DATA_W-1:0]        out_tdata,  // dot_product, cosine, zero pad
  output logic [csim_pkg::OUT_USER_W-1:0]        out_tuser   // zero_norm, too_long
);

  logic                            q_push;
  csim_pkg::csim_entry_t           push_entry;
  logic                            q_pop;
  logic                            q_valid;
  csim_pkg::csim_entry_t           q_entry;
  logic [csim_pkg::Q_CNT_W-1:0]    q_count;

  // Accumulates sums at stream rate.
  csim_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_count   (q_count),
    .q_push    (q_push),
    .q_entry   (push_entry)
  );

  // Decouples the stream from the long back-end computation.
  csim_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (push_entry),
    .pop        (q_pop),
    .q_valid    (q_valid),
    .q_entry    (q_entry),
    .q_count    (q_count)
  );

  // Norm product, root, divide, clamp and result register.
  csim_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_entry    (q_entry),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

`default_nettype wire
